// ----- rtl/core/bmhq_pkg.sv -----
// binary min-heap queue: shared types, sizes and codes
// used by bmhq_store and binary_min_heap_queue; depends on nothing
package bmhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 16;
    localparam int TAG_BITS  = 16;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // request codes
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_INSERTED  = 2'd0;
    localparam logic [1:0] STAT_EXTRACTED = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } slot_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] vertex;
        logic [15:0] dist_req;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_vertex;
        logic [15:0] out_dist;
        logic [10:0] fill;
    } rsp_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        slot_t                data;
    } mem_wr_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
    } mem_rd_t;

endpackage

// ----- rtl/core/bmhq_store.sv -----
// heap entry storage: one write port, one read port with registered data
// depends on bmhq_pkg
module bmhq_store (
    input  logic              clk,
    input  bmhq_pkg::mem_wr_t wr,
    input  bmhq_pkg::mem_rd_t rd,
    output bmhq_pkg::slot_t   rd_data
);

    bmhq_pkg::slot_t mem [bmhq_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// binary min-heap priority queue: sequencer, entry count and result register
// depends on bmhq_pkg and bmhq_store
// insert climbs from the new last slot toward the root; extract reads the root and
//   the last entry, then sifts down; full or empty go straight to delivery;
//   the next request is taken in the cycle after the result loads
// one request at a time: every level costs store reads on the single port and one
//   key compare, so the sift walk of log2(capacity) levels sets the rate
// reset clears the entry count and all control state; store contents stay undefined
//   and only entries below the count are ever read
module binary_min_heap_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bmhq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bmhq_pkg::rsp_t rsp
);

    localparam int AB = bmhq_pkg::ADDR_BITS;
    localparam int CB = bmhq_pkg::CNT_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;  // read parent or settle at root
    localparam logic [3:0] S_UP_CMP   = 4'd2;  // compare with parent, move one
    localparam logic [3:0] S_EX_ROOT  = 4'd3;  // read root
    localparam logic [3:0] S_EX_LAST  = 4'd4;  // read last entry, root data back
    localparam logic [3:0] S_EX_WAIT  = 4'd5;  // last entry data back
    localparam logic [3:0] S_DN_RD_L  = 4'd6;  // read left child or settle
    localparam logic [3:0] S_DN_RD_R  = 4'd7;  // read right child, left back
    localparam logic [3:0] S_DN_CMP   = 4'd8;  // pick smallest, move one
    localparam logic [3:0] S_DELIVER  = 4'd9;  // hand result to output register

    logic [3:0]      state_reg, state_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [AB-1:0]   idx_reg, idx_next;
    bmhq_pkg::slot_t cur_reg, cur_next;       // entry being sifted
    bmhq_pkg::slot_t left_reg, left_next;     // left child during sift-down
    bmhq_pkg::rsp_t  pend_reg, pend_next;     // result under construction
    bmhq_pkg::rsp_t  rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    bmhq_pkg::mem_wr_t wr;
    bmhq_pkg::mem_rd_t rd;
    bmhq_pkg::slot_t   rd_data;

    // child and parent index math
    logic [AB:0]   left_idx;
    logic [AB+1:0] right_idx;
    logic          left_in;
    logic          right_in;
    logic [AB-1:0] parent_idx;
    logic          req_take;
    logic          out_free;

    bmhq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign left_idx   = {idx_reg, 1'b1};
    assign right_idx  = {1'b0, left_idx} + (AB + 2)'(1);
    assign left_in    = left_idx < count_reg;
    assign right_in   = right_idx < {1'b0, count_reg};
    assign parent_idx = (idx_reg - AB'(1)) >> 1;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic            use_l;
        logic            use_r;
        bmhq_pkg::slot_t best;

        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr             = '0;
        rd             = '0;
        use_l          = 1'b0;
        use_r          = 1'b0;
        best           = cur_reg;

        // result beat leaves when taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    pend_next = '0;
                    if (req.req_type == bmhq_pkg::REQ_INSERT)
                    begin
                        if (count_reg == CB'(bmhq_pkg::CAPACITY))
                        begin
                            pend_next.status = bmhq_pkg::STAT_FULL;
                            pend_next.fill   = 11'(count_reg);
                            state_next       = S_DELIVER;
                        end
                        else
                        begin
                            cur_next.key     = bmhq_pkg::KEY_BITS'(req.dist_req);
                            cur_next.tag     = bmhq_pkg::TAG_BITS'(req.vertex);
                            idx_next         = count_reg[AB-1:0];
                            count_next       = count_reg + CB'(1);
                            pend_next.status = bmhq_pkg::STAT_INSERTED;
                            pend_next.fill   = 11'(count_reg + CB'(1));
                            state_next       = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_next.status = bmhq_pkg::STAT_EMPTY;
                            state_next       = S_DELIVER;
                        end
                        else
                        begin
                            count_next       = count_reg - CB'(1);
                            pend_next.status = bmhq_pkg::STAT_EXTRACTED;
                            pend_next.fill   = 11'(count_reg - CB'(1));
                            state_next       = S_EX_ROOT;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = idx_reg;
                    wr.data    = cur_reg;
                    state_next = S_DELIVER;
                end
                else
                begin
                    rd.en      = 1'b1;
                    rd.addr    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr.en   = 1'b1;
                wr.addr = idx_reg;
                if (cur_reg.key < rd_data.key)
                begin
                    // parent moves down, keep climbing
                    wr.data    = rd_data;
                    idx_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    wr.data    = cur_reg;
                    state_next = S_DELIVER;
                end
            end

            S_EX_ROOT:
            begin
                rd.en      = 1'b1;
                rd.addr    = '0;
                state_next = S_EX_LAST;
            end

            S_EX_LAST:
            begin
                // count already points at the last entry
                rd.en                = 1'b1;
                rd.addr              = count_reg[AB-1:0];
                pend_next.out_vertex = 16'(rd_data.tag);
                pend_next.out_dist   = 16'(rd_data.key);
                state_next           = S_EX_WAIT;
            end

            S_EX_WAIT:
            begin
                cur_next = rd_data;
                idx_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DELIVER;
                end
                else
                begin
                    state_next = S_DN_RD_L;
                end
            end

            S_DN_RD_L:
            begin
                if (!left_in)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = idx_reg;
                    wr.data    = cur_reg;
                    state_next = S_DELIVER;
                end
                else
                begin
                    rd.en      = 1'b1;
                    rd.addr    = left_idx[AB-1:0];
                    state_next = S_DN_RD_R;
                end
            end

            S_DN_RD_R:
            begin
                left_next = rd_data;
                if (right_in)
                begin
                    rd.en   = 1'b1;
                    rd.addr = right_idx[AB-1:0];
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                // strictly smaller child wins, left on ties
                use_l = left_reg.key < cur_reg.key;
                best  = use_l ? left_reg : cur_reg;
                use_r = right_in && (rd_data.key < best.key);
                if (use_r)
                begin
                    best = rd_data;
                end
                wr.en   = 1'b1;
                wr.addr = idx_reg;
                if (use_l || use_r)
                begin
                    wr.data    = best;
                    idx_next   = use_r ? right_idx[AB-1:0] : left_idx[AB-1:0];
                    state_next = S_DN_RD_L;
                end
                else
                begin
                    wr.data    = cur_reg;
                    state_next = S_DELIVER;
                end
            end

            S_DELIVER:
            begin
                if (out_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        left_reg <= left_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule
